// ===== rtl/core/single_wire_humidity_sensor_reader_assert.svh =====
// assertion macros for the single-wire humidity sensor reader
// expects clk and arst_n in the scope where a macro is used
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH

// same-cycle implication
`define SWHS_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("swhs same-cycle check failed");

// next-cycle implication
`define SWHS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("swhs next-cycle check failed");

`endif

// ===== rtl/core/swhs_pkg.sv =====
// shared types and constants for the single-wire humidity sensor reader
// no dependencies
package swhs_pkg;

	localparam int unsigned FRAME_BITS_DEF = 40;
	localparam int unsigned FRAME_MAX      = 64;
	localparam int unsigned CNT_W          = 16;
	localparam int unsigned CFG_W          = 16;
	localparam int unsigned IDX_W          = 3;
	localparam int unsigned QUEUE_DEPTH    = 2;

	localparam logic [15:0] REQUEST_LOW_RST   = 16'd10000;
	localparam logic [7:0]  RELEASE_WAIT_RST  = 8'd40;
	localparam logic [15:0] BUSY_TIMEOUT_RST  = 16'd1000;
	localparam logic [15:0] PULSE_TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  ONE_THRESHOLD_RST = 8'd50;

	localparam logic [IDX_W-1:0] REG_REQUEST_LOW   = 3'd0;
	localparam logic [IDX_W-1:0] REG_RELEASE_WAIT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_BUSY_TIMEOUT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_PULSE_TIMEOUT = 3'd3;
	localparam logic [IDX_W-1:0] REG_ONE_THRESHOLD = 3'd4;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BUSYWAIT,
		PH_REQUEST,
		PH_RELEASE,
		PH_ACKLOW,
		PH_ACKHIGH,
		PH_DATALOW,
		PH_DATAHIGH
	} phase_t;

	typedef enum logic [1:0] {
		OP_TICK_LOW,
		OP_TICK_HIGH,
		OP_START
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_BUSY_LINE   = 3'd1,
		ERR_NO_ACK      = 3'd2,
		ERR_CHECKSUM    = 3'd3,
		ERR_BIT_TIMEOUT = 3'd4
	} err_t;

	typedef struct packed {
		logic [15:0] request_low;
		logic [7:0]  release_wait;
		logic [15:0] busy_timeout;
		logic [15:0] pulse_timeout;
		logic [7:0]  one_threshold;
	} cfg_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} qhead_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		err_t        error_code;
		logic [15:0] humidity_tenths;
		logic [15:0] temp_tenths;
	} result_t;

endpackage

// ===== rtl/core/swhs_in_if.sv =====
// input channel of the sensor reader: tick or start items
// no dependencies
interface swhs_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic pin_level;

	modport source (output valid, kind, pin_level, input ready);
	modport sink (input valid, kind, pin_level, output ready);
endinterface

// ===== rtl/core/swhs_out_if.sv =====
// result channel of the sensor reader
// no dependencies
interface swhs_out_if;
	logic        valid;
	logic        ready;
	logic        drive_low;
	logic        busy_res;
	logic        done_res;
	logic [2:0]  error_code;
	logic [15:0] humidity_tenths;
	logic [15:0] temp_tenths;

	modport source (output valid, drive_low, busy_res, done_res, error_code,
		humidity_tenths, temp_tenths, input ready);
	modport sink (input valid, drive_low, busy_res, done_res, error_code,
		humidity_tenths, temp_tenths, output ready);
endinterface

// ===== rtl/core/swhs_front.sv =====
// front end: accepts items, decodes them into ops and queues them
// depends on swhs_pkg and swhs_in_if
module swhs_front import swhs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	swhs_in_if.sink   in_ch,
	input  logic      pop,
	output qhead_t    head
);
	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

	op_t             slot_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	op_t             op_in;
	logic            push;
	logic            pop_ok;

	always_comb begin
		if (in_ch.kind == KIND_START) begin
			op_in = OP_START;
		end else if (in_ch.pin_level) begin
			op_in = OP_TICK_HIGH;
		end else begin
			op_in = OP_TICK_LOW;
		end
	end

	assign in_ch.ready = (fill_q != CntW'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign pop_ok      = pop && head.valid;
	assign head.valid  = (fill_q != '0);
	assign head.op     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop_ok})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule

// ===== rtl/core/swhs_back.sv =====
// back end: transaction state machine, pulse timing, frame check, result register
// depends on swhs_pkg and swhs_out_if
module swhs_back import swhs_pkg::*; #(
	parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  qhead_t     head,
	output logic       pop,
	swhs_out_if.source out_ch
);
	localparam int unsigned BitsW  = $clog2(FRAME_BITS + 1);
	localparam int unsigned NBytes = FRAME_BITS / 8;

	phase_t                ph_q, ph_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
	logic [BitsW-1:0]      bits_q, bits_d, bits_inc;
	logic [FRAME_BITS-1:0] frame_q, frame_d, frame_sh;
	logic [FRAME_MAX-1:0]  frame_ext;
	logic [7:0]            sum;
	logic                  bit_val;
	logic                  done;
	err_t                  err;
	logic [15:0]           hum;
	logic [15:0]           tmp;
	logic                  out_valid_q;
	result_t               res_q;

	assign pop = head.valid && (!out_valid_q || out_ch.ready);

	assign cnt_inc   = cnt_q + 1'b1;
	assign bits_inc  = bits_q + 1'b1;
	assign bit_val   = (cnt_q > {8'd0, cfg.one_threshold});
	assign frame_sh  = {frame_q[FRAME_BITS-2:0], bit_val};
	assign frame_ext = FRAME_MAX'(frame_sh);

	always_comb begin
		sum = '0;
		for (int k = 1; k < NBytes; k++) begin
			sum = sum + frame_ext[8*k +: 8];
		end
	end

	always_comb begin
		ph_d    = ph_q;
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		frame_d = frame_q;
		done    = 1'b0;
		err     = ERR_OK;
		hum     = '0;
		tmp     = '0;
		if (head.op == OP_START) begin
			if (ph_q == PH_IDLE) begin
				ph_d    = PH_BUSYWAIT;
				cnt_d   = '0;
				bits_d  = '0;
				frame_d = '0;
			end
		end else begin
			case (ph_q)
				PH_BUSYWAIT: begin
					if (head.op == OP_TICK_HIGH) begin
						ph_d  = PH_REQUEST;
						cnt_d = '0;
					end else if (cnt_q >= cfg.busy_timeout) begin
						done = 1'b1;
						err  = ERR_BUSY_LINE;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_REQUEST: begin
					if (cnt_inc >= cfg.request_low) begin
						ph_d  = PH_RELEASE;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_RELEASE: begin
					if (cnt_inc >= {8'd0, cfg.release_wait}) begin
						ph_d  = PH_ACKLOW;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_ACKLOW: begin
					if (head.op == OP_TICK_HIGH) begin
						ph_d  = PH_ACKHIGH;
						cnt_d = CNT_W'(1);
					end else if (cnt_q >= cfg.pulse_timeout) begin
						done = 1'b1;
						err  = ERR_NO_ACK;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_ACKHIGH: begin
					if (head.op == OP_TICK_LOW) begin
						ph_d  = PH_DATALOW;
						cnt_d = CNT_W'(1);
					end else if (cnt_q >= cfg.pulse_timeout) begin
						done = 1'b1;
						err  = ERR_NO_ACK;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_DATALOW: begin
					if (head.op == OP_TICK_HIGH) begin
						ph_d  = PH_DATAHIGH;
						cnt_d = CNT_W'(1);
					end else if (cnt_q >= cfg.pulse_timeout) begin
						done = 1'b1;
						err  = ERR_BIT_TIMEOUT;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_DATAHIGH: begin
					if (head.op == OP_TICK_LOW) begin
						frame_d = frame_sh;
						bits_d  = bits_inc;
						if (bits_inc >= BitsW'(FRAME_BITS)) begin
							done = 1'b1;
							if (sum != frame_ext[7:0]) begin
								err = ERR_CHECKSUM;
							end else begin
								hum = frame_ext[39:24];
								tmp = frame_ext[23:8];
							end
						end else begin
							ph_d  = PH_DATALOW;
							cnt_d = CNT_W'(1);
						end
					end else if (cnt_q >= cfg.pulse_timeout) begin
						done = 1'b1;
						err  = ERR_BIT_TIMEOUT;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				default: begin
					ph_d = ph_q;
				end
			endcase
		end
		// any transaction end returns to idle with a cleared counter
		if (done) begin
			ph_d  = PH_IDLE;
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			cnt_q       <= '0;
			bits_q      <= '0;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ph_q        <= ph_d;
				cnt_q       <= cnt_d;
				bits_q      <= bits_d;
				frame_q     <= frame_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.drive_low       <= (ph_d == PH_REQUEST);
			res_q.busy_res        <= (ph_d != PH_IDLE);
			res_q.done_res        <= done;
			res_q.error_code      <= err;
			res_q.humidity_tenths <= hum;
			res_q.temp_tenths     <= tmp;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.drive_low       = res_q.drive_low;
	assign out_ch.busy_res        = res_q.busy_res;
	assign out_ch.done_res        = res_q.done_res;
	assign out_ch.error_code      = res_q.error_code;
	assign out_ch.humidity_tenths = res_q.humidity_tenths;
	assign out_ch.temp_tenths     = res_q.temp_tenths;
endmodule

// ===== rtl/core/single_wire_humidity_sensor_reader.sv =====
// single-wire humidity / temperature sensor reader, master side
// in_ch carries one item per microsecond: a tick with the sampled line level,
// or a start request. out_ch returns exactly one result per item: the line
// drive, busy flag, and on the item that ends a read the done flag, error code
// and the raw humidity and temperature words in tenths.
// the cfg write port sets request, release, timeout and threshold times;
// write only while no items are in flight.
// path from accept to result: the decode queue, then the state machine into the
// result register. one item per cycle while the receiver takes results, as the
// back end updates its state on every item that it pops from the queue.
// a 2-entry queue decouples the decoder from the state machine, so input is
// still taken while a result waits; when the receiver stalls, the result
// register holds, the queue fills and in_ch.ready drops after two more items.
// reset: idle phase, counters and frame cleared, registers at their defaults,
// queue and result register empty.
// depends on swhs_pkg, swhs_in_if, swhs_out_if, swhs_front, swhs_back and the assert header
`include "single_wire_humidity_sensor_reader_assert.svh"

module single_wire_humidity_sensor_reader import swhs_pkg::*; #(
	parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	swhs_in_if.sink          in_ch,
	swhs_out_if.source       out_ch,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);
	cfg_t   cfg_q;
	qhead_t q_head;
	logic   q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.request_low   <= REQUEST_LOW_RST;
			cfg_q.release_wait  <= RELEASE_WAIT_RST;
			cfg_q.busy_timeout  <= BUSY_TIMEOUT_RST;
			cfg_q.pulse_timeout <= PULSE_TIMEOUT_RST;
			cfg_q.one_threshold <= ONE_THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_REQUEST_LOW:   cfg_q.request_low   <= cfg_wdata;
				REG_RELEASE_WAIT:  cfg_q.release_wait  <= cfg_wdata[7:0];
				REG_BUSY_TIMEOUT:  cfg_q.busy_timeout  <= cfg_wdata;
				REG_PULSE_TIMEOUT: cfg_q.pulse_timeout <= cfg_wdata;
				REG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_wdata[7:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	swhs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (q_pop),
		.head   (q_head)
	);

	swhs_back #(
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (q_head),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

	`SWHS_ASSERT_SAME(a_done_ends_busy, out_ch.valid && out_ch.done_res, !out_ch.busy_res && !out_ch.drive_low)
	`SWHS_ASSERT_SAME(a_err_only_when_done, out_ch.valid && !out_ch.done_res, out_ch.error_code == ERR_OK)
	`SWHS_ASSERT_SAME(a_drive_implies_busy, out_ch.valid && out_ch.drive_low, out_ch.busy_res)
	`SWHS_ASSERT_NEXT(a_accept_fills_queue, in_ch.valid && in_ch.ready, q_head.valid)
endmodule
